### rtl/core/gceb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gceb_pkg: shared types and constants for the grid cell entity bins unit
// Item layouts, status and operation codes, register indexes, sequencer
// states and default sizes.
// ----------------------------------------------------------------------------
package gceb_pkg;

	// Default sizes
	localparam int SLOTS_PER_CELL_DEF = 16;
	localparam int MAX_SIDE_DEF       = 64;
	localparam int ID_BITS_DEF        = 16;

	// Field widths fixed by the interface
	localparam int FUNC_W      = 1;
	localparam int COORD_W     = 6;
	localparam int ENTITY_W    = 16;
	localparam int STATUS_W    = 2;
	localparam int NEW_COUNT_W = 5;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;

	// Register reset values
	localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
	localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_ADD    = 1'b0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_COUNT,
		S_SCAN,
		S_MOVE,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [COORD_W-1:0]  cell_x;
		logic [COORD_W-1:0]  cell_y;
		logic [ENTITY_W-1:0] entity_id;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [NEW_COUNT_W-1:0] new_count;
	} rsp_item_t;

endpackage

### rtl/core/gceb_count_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gceb_count_store: per-cell entity count memory
// One synchronous port (shared address); rd_data follows rd_en next cycle.
// After reset, sweeps every entry to zero and flags busy until done.
// ----------------------------------------------------------------------------
module gceb_count_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic          wr_en,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data,
	output logic          busy
);

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          busy_q;

	// Clearing sweep: one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

	assign busy = busy_q;

endmodule

### rtl/core/gceb_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gceb_slot_store: entity id slot memory
// One synchronous port (shared address); rd_data follows rd_en next cycle.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module gceb_slot_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic          wr_en,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule

### rtl/core/grid_cell_entity_bins_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_entity_bins_unit: uniform grid of per-cell entity id buckets
// Adds an id to, or removes an id from, the bucket of one grid cell and
// reports a status and the cell's new count for every request item.
// ----------------------------------------------------------------------------
//
//  channel | ports                        | dir | moves
//  --------+------------------------------+-----+--------------------------------
//  req     | req_valid, req_ready, req    | in  | func, cell_x, cell_y, entity_id
//  rsp     | rsp_valid, rsp_ready, rsp    | out | status, new_count
//  cfg     | cfg_we, cfg_index, cfg_data  | in  | grid_width (0), grid_height (1)
//
// Sequence: one item at a time. After acceptance, LOOK checks the bounds;
//   an item out of range goes straight to RESULT. Otherwise COUNT takes the
//   cell's count: an add or a remove from an empty bucket goes to RESULT,
//   any other remove scans k slots in SCAN (k from 1 up to SLOTS_PER_CELL),
//   as the slot memory port reads one slot per cycle; a hit passes MOVE
//   before RESULT. The next item is taken after the load, back in IDLE.
// Reset: the count memory is swept to zero, one cell per cycle, over all
//   MAX_SIDE * MAX_SIDE cells (4096 at the defaults); req_ready stays low
//   meanwhile. Configuration writes are taken at any time.
// Stalls: the result register lets the next item be accepted while a result
//   waits; a finished item holds in the result state until the register frees.
//
// Each item's memory writes land before the next item's first read, so no
// forwarding is needed between items.
// ----------------------------------------------------------------------------
module grid_cell_entity_bins_unit #(
	parameter int SLOTS_PER_CELL = gceb_pkg::SLOTS_PER_CELL_DEF,
	parameter int MAX_SIDE       = gceb_pkg::MAX_SIDE_DEF,
	parameter int ID_BITS        = gceb_pkg::ID_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  gceb_pkg::req_item_t                req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output gceb_pkg::rsp_item_t                rsp,
	input  logic                               cfg_we,
	input  logic [gceb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gceb_pkg::CFG_W-1:0]         cfg_data
);

	localparam int NUM_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int NUM_SLOTS = NUM_CELLS * SLOTS_PER_CELL;
	localparam int CELL_W    = $clog2(NUM_CELLS);
	localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS_PER_CELL + 1);
	localparam int SIDX_W    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
	localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
	localparam int CW        = gceb_pkg::CFG_W;
	localparam int EW        = (SIDE_W > CW) ? SIDE_W : CW;
	localparam int PW        = CELL_W + CW;
	localparam int ID_KEEP   = (ID_BITS < gceb_pkg::ENTITY_W) ? ID_BITS : gceb_pkg::ENTITY_W;
	localparam int NCW       = gceb_pkg::NEW_COUNT_W;

	// ---------------- configuration registers ----------------
	logic [CW-1:0] grid_width_q;
	logic [CW-1:0] grid_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= gceb_pkg::GRID_WIDTH_RST;
			grid_height_q <= gceb_pkg::GRID_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == gceb_pkg::CFG_GRID_WIDTH) begin
				grid_width_q <= cfg_data;
			end
			if (cfg_index == gceb_pkg::CFG_GRID_HEIGHT) begin
				grid_height_q <= cfg_data;
			end
		end
	end

	// ---------------- item and working registers ----------------
	gceb_pkg::state_t    state_q, state_d;
	gceb_pkg::req_item_t item_q;
	logic [ID_BITS-1:0]  id_q;
	logic [ID_BITS-1:0]  id_in;
	logic [CELL_W-1:0]   cell_q;
	logic [SLOT_AW-1:0]  base_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SIDX_W-1:0]   idx_q;
	logic [SIDX_W-1:0]   hit_q;
	gceb_pkg::status_t   res_status_q, res_status_d;
	logic [CNT_W-1:0]    res_count_q, res_count_d;
	logic                res_set;
	logic                rsp_load;
	logic                rsp_valid_q;
	gceb_pkg::rsp_item_t rsp_q;

	// Take the low ID_BITS of the entity id, zero-extend above 16 bits
	always_comb begin
		id_in = '0;
		id_in[ID_KEEP-1:0] = req.entity_id[ID_KEEP-1:0];
	end

	// ---------------- bounds check and cell index ----------------
	logic [EW-1:0]     side_max, w_ext, h_ext, w_eff, h_eff, x_ext, y_ext;
	logic              in_range;
	logic [PW-1:0]     cell_prod;
	logic [CELL_W-1:0] cell_d;

	always_comb begin
		side_max  = EW'(MAX_SIDE);
		w_ext     = EW'(grid_width_q);
		h_ext     = EW'(grid_height_q);
		// clamp oversize registers to the grid side
		w_eff     = (w_ext > side_max) ? side_max : w_ext;
		h_eff     = (h_ext > side_max) ? side_max : h_ext;
		x_ext     = EW'(item_q.cell_x);
		y_ext     = EW'(item_q.cell_y);
		in_range  = (x_ext < w_eff) && (y_ext < h_eff);
		cell_prod = PW'(item_q.cell_y) * PW'(w_eff) + PW'(item_q.cell_x);
		cell_d    = CELL_W'(cell_prod);
	end

	// ---------------- memories ----------------
	logic                cnt_rd, cnt_we, cnt_busy;
	logic [CELL_W-1:0]   cnt_addr;
	logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
	logic                slot_rd, slot_we;
	logic [SLOT_AW-1:0]  slot_addr;
	logic [ID_BITS-1:0]  slot_wdata, slot_rdata;

	gceb_count_store #(
		.DEPTH (NUM_CELLS),
		.AW    (CELL_W),
		.DW    (CNT_W)
	) u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (cnt_rd),
		.wr_en   (cnt_we),
		.addr    (cnt_addr),
		.wr_data (cnt_wdata),
		.rd_data (cnt_rdata),
		.busy    (cnt_busy)
	);

	gceb_slot_store #(
		.DEPTH (NUM_SLOTS),
		.AW    (SLOT_AW),
		.DW    (ID_BITS)
	) u_slots (
		.clk     (clk),
		.rd_en   (slot_rd),
		.wr_en   (slot_we),
		.addr    (slot_addr),
		.wr_data (slot_wdata),
		.rd_data (slot_rdata)
	);

	// ---------------- sequencer ----------------
	assign req_ready = (state_q == gceb_pkg::S_IDLE) && !cnt_busy;

	logic             scan_hit, scan_more;
	logic [CNT_W-1:0] idx_next_c;

	assign idx_next_c = CNT_W'(idx_q) + CNT_W'(1);
	assign scan_hit   = (slot_rdata == id_q);
	assign scan_more  = idx_next_c < cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gceb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_rd       = 1'b0;
		cnt_we       = 1'b0;
		cnt_addr     = cell_q;
		cnt_wdata    = '0;
		slot_rd      = 1'b0;
		slot_we      = 1'b0;
		slot_addr    = base_q;
		slot_wdata   = id_q;
		res_set      = 1'b0;
		res_status_d = gceb_pkg::ST_DONE;
		res_count_d  = '0;
		rsp_load     = 1'b0;
		case (state_q)
			gceb_pkg::S_IDLE: begin
				if (req_valid && req_ready) begin
					state_d = gceb_pkg::S_LOOK;
				end
			end
			gceb_pkg::S_LOOK: begin
				if (!in_range) begin
					// outside the grid: touch nothing, count reads as zero
					res_set      = 1'b1;
					res_status_d = gceb_pkg::ST_RANGE;
					state_d      = gceb_pkg::S_RESULT;
				end else begin
					cnt_rd   = 1'b1;
					cnt_addr = cell_d;
					state_d  = gceb_pkg::S_COUNT;
				end
			end
			gceb_pkg::S_COUNT: begin
				if (item_q.func == gceb_pkg::FN_ADD) begin
					res_set = 1'b1;
					state_d = gceb_pkg::S_RESULT;
					if (cnt_rdata >= CNT_W'(SLOTS_PER_CELL)) begin
						res_status_d = gceb_pkg::ST_FULL;
						res_count_d  = cnt_rdata;
					end else begin
						// append at the end of the bucket
						slot_we      = 1'b1;
						slot_addr    = base_q + SLOT_AW'(cnt_rdata);
						cnt_we       = 1'b1;
						cnt_wdata    = cnt_rdata + CNT_W'(1);
						res_status_d = gceb_pkg::ST_DONE;
						res_count_d  = cnt_rdata + CNT_W'(1);
					end
				end else if (cnt_rdata == '0) begin
					res_set      = 1'b1;
					res_status_d = gceb_pkg::ST_MISSING;
					state_d      = gceb_pkg::S_RESULT;
				end else begin
					// start the scan at slot zero
					slot_rd = 1'b1;
					state_d = gceb_pkg::S_SCAN;
				end
			end
			gceb_pkg::S_SCAN: begin
				if (scan_hit) begin
					// fetch the last entry to fill the hole
					slot_rd   = 1'b1;
					slot_addr = base_q + SLOT_AW'(cnt_q - CNT_W'(1));
					state_d   = gceb_pkg::S_MOVE;
				end else if (scan_more) begin
					slot_rd   = 1'b1;
					slot_addr = base_q + SLOT_AW'(idx_next_c);
				end else begin
					res_set      = 1'b1;
					res_status_d = gceb_pkg::ST_MISSING;
					res_count_d  = cnt_q;
					state_d      = gceb_pkg::S_RESULT;
				end
			end
			gceb_pkg::S_MOVE: begin
				slot_we      = 1'b1;
				slot_addr    = base_q + SLOT_AW'(hit_q);
				slot_wdata   = slot_rdata;
				cnt_we       = 1'b1;
				cnt_wdata    = cnt_q - CNT_W'(1);
				res_set      = 1'b1;
				res_status_d = gceb_pkg::ST_DONE;
				res_count_d  = cnt_q - CNT_W'(1);
				state_d      = gceb_pkg::S_RESULT;
			end
			gceb_pkg::S_RESULT: begin
				// hold until the result register is free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = gceb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gceb_pkg::S_IDLE;
			end
		endcase
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
			id_q   <= id_in;
		end
		if (state_q == gceb_pkg::S_LOOK) begin
			cell_q <= cell_d;
			base_q <= SLOT_AW'(cell_d) * SLOT_AW'(SLOTS_PER_CELL);
		end
		if (state_q == gceb_pkg::S_COUNT) begin
			cnt_q <= cnt_rdata;
			idx_q <= '0;
		end
		if (state_q == gceb_pkg::S_SCAN) begin
			if (scan_hit) begin
				hit_q <= idx_q;
			end else if (scan_more) begin
				idx_q <= SIDX_W'(idx_next_c);
			end
		end
		if (res_set) begin
			res_status_q <= res_status_d;
			res_count_q  <= res_count_d;
		end
		if (rsp_load) begin
			rsp_q.status    <= res_status_q;
			rsp_q.new_count <= NCW'(res_count_q);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_busy |-> !req_ready)
		else $error("item accepted during count memory sweep");

	a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == gceb_pkg::S_LOOK))
		else $error("accepted item did not start lookup");

	a_count_write_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wdata <= CNT_W'(SLOTS_PER_CELL)))
		else $error("count write exceeds bucket capacity");

	a_range_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == gceb_pkg::ST_RANGE)) |-> (rsp.new_count == '0))
		else $error("out of range result carries a nonzero count");

endmodule
